@@ hw/rtl/fss_pkg.sv @@
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the flash slot rotation store.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

	localparam int SLOT_WORDS  = 128;
	localparam int NUM_SLOTS   = 32;
	localparam int STORE_WORDS = SLOT_WORDS * NUM_SLOTS;

	localparam int DATA_W     = 32;
	localparam int INDEX_W    = 7;
	localparam int SLOT_OUT_W = 6;
	localparam int ADDR_W     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	// Slot register also holds NUM_SLOTS itself, which means not located.
	localparam int SLOT_W     = $clog2(NUM_SLOTS + 1);
	localparam int SIDX_W     = $clog2(NUM_SLOTS);
	localparam int CNT_W      = $clog2(SLOT_WORDS + 1);
	localparam int LIM_W      = 11;

	localparam logic [DATA_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_LOCATE  = 2'd0,
		CMD_READ    = 2'd1,
		CMD_WRITE   = 2'd2,
		CMD_ADVANCE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_SCAN_SLOT,
		ST_SCAN_WORDS,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} ram_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/flash_slot_rotation_store.sv @@
// Results: advance, and write to a slot already in use, give the result in the cycle after the
// transaction, as does any read not of a slot in use; read from a slot in use first registers
// the memory word; write to a fresh slot first fills the slot. Locate steps past each untouched
// slot and scans the words of each used slot, since one memory port reads a word per cycle.
// Throughput: one transaction at a time; the next is taken once the result register is free.
// Reset: in-use flags clear at once, as on an erase; input is ready after reset.
// ----------------------------------------------------------------------------
// flash_slot_rotation_store
// Sector of rotating slots with locate, word read/write and advance/erase.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_slot_rotation_store
	import fss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // word_index[6:0], write_data[38:7], zero pad
	input  wire logic [1:0]  s_tuser,   // command[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // read_data[31:0], slot_number[37:32], zero pad
	output logic      [0:0]  m_tuser    // status[0]
);

	state_t state_q, state_d;

	logic [SLOT_W-1:0]    cur_slot_q, cur_d;
	logic [NUM_SLOTS-1:0] slot_valid_q;
	logic [SIDX_W-1:0]    scan_slot_q;
	logic [CNT_W-1:0]     word_cnt_q;
	logic                 chk_s1, last_s1;
	cmd_t                 cmd_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [DATA_W-1:0]    wdata_q;

	logic                  out_valid_q;
	logic                  out_status_q;
	logic [DATA_W-1:0]     out_data_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;

	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;

	cmd_t               cmd;
	logic [INDEX_W-1:0] idx;
	logic [DATA_W-1:0]  wdata;
	logic               out_free, acc, located, idx_ok, rw_ok, cur_valid;
	logic [SIDX_W-1:0]  cur_idx;
	logic [ADDR_W-1:0]  cur_base, scan_base;
	logic               issue, found, blank_done, fill_last;

	logic              load_out, res_status;
	logic [DATA_W-1:0] res_data;
	logic              valid_set, valid_clr, scan_load, scan_dec, cnt_clr, cnt_inc;
	logic              latch_cmd, latch_wr;

	assign cmd   = cmd_t'(s_tuser);
	assign idx   = s_tdata[6:0];
	assign wdata = s_tdata[38:7];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;

	assign located   = cur_slot_q < SLOT_W'(NUM_SLOTS);
	assign idx_ok    = LIM_W'(idx) < LIM_W'(SLOT_WORDS);
	assign rw_ok     = located && idx_ok;
	assign cur_idx   = cur_slot_q[SIDX_W-1:0];
	assign cur_valid = slot_valid_q[cur_idx];
	assign cur_base  = ADDR_W'(cur_idx) * ADDR_W'(SLOT_WORDS);
	assign scan_base = ADDR_W'(scan_slot_q) * ADDR_W'(SLOT_WORDS);

	assign issue      = (state_q == ST_SCAN_WORDS) && (word_cnt_q != CNT_W'(SLOT_WORDS));
	assign found      = chk_s1 && (ram_rdata != ERASED_WORD);
	assign blank_done = chk_s1 && last_s1 && !found;
	assign fill_last  = word_cnt_q == CNT_W'(SLOT_WORDS - 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_LOCATE: state_d = ST_SCAN_SLOT;
						CMD_READ:   if (rw_ok && cur_valid) state_d = ST_RESP;
						CMD_WRITE:  if (rw_ok && !cur_valid) state_d = ST_FILL;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL:       if (fill_last) state_d = ST_RESP;
			ST_SCAN_SLOT: begin
				if (scan_slot_q == '0) begin
					state_d = ST_RESP;
				end else if (slot_valid_q[scan_slot_q]) begin
					state_d = ST_SCAN_WORDS;
				end
			end
			ST_SCAN_WORDS: begin
				if (found) begin
					state_d = ST_RESP;
				end else if (blank_done) begin
					state_d = ST_SCAN_SLOT;
				end
			end
			ST_RESP:       if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Datapath controls.
	always_comb begin
		ram_req    = '0;
		load_out   = 1'b0;
		res_status = 1'b0;
		res_data   = '0;
		cur_d      = cur_slot_q;
		valid_set  = 1'b0;
		valid_clr  = 1'b0;
		scan_load  = 1'b0;
		scan_dec   = 1'b0;
		cnt_clr    = 1'b0;
		cnt_inc    = 1'b0;
		latch_cmd  = 1'b0;
		latch_wr   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					latch_cmd = 1'b1;
					case (cmd)
						CMD_LOCATE: scan_load = 1'b1;
						CMD_READ: begin
							if (rw_ok && cur_valid) begin
								ram_req.re   = 1'b1;
								ram_req.addr = cur_base + ADDR_W'(idx);
							end else begin
								// A slot never written since the last erase reads as erased.
								load_out   = 1'b1;
								res_status = !located;
								res_data   = rw_ok ? ERASED_WORD : '0;
							end
						end
						CMD_WRITE: begin
							if (rw_ok && !cur_valid) begin
								latch_wr = 1'b1;
								cnt_clr  = 1'b1;
							end else begin
								ram_req.we    = rw_ok;
								ram_req.addr  = cur_base + ADDR_W'(idx);
								ram_req.wdata = wdata;
								load_out      = 1'b1;
								res_status    = !located;
							end
						end
						default: begin
							load_out = 1'b1;
							if (cur_slot_q < SLOT_W'(NUM_SLOTS - 1)) begin
								cur_d = cur_slot_q + SLOT_W'(1);
							end else begin
								valid_clr = 1'b1;
								cur_d     = '0;
							end
						end
					endcase
				end
			end
			ST_FILL: begin
				// Bring the fresh slot to erased words, merging the pending write.
				ram_req.we    = 1'b1;
				ram_req.addr  = cur_base + ADDR_W'(word_cnt_q);
				ram_req.wdata = (word_cnt_q == CNT_W'(idx_q)) ? wdata_q : ERASED_WORD;
				cnt_inc       = 1'b1;
				valid_set     = fill_last;
			end
			ST_SCAN_SLOT: begin
				if (scan_slot_q == '0) begin
					cur_d = '0;
				end else if (slot_valid_q[scan_slot_q]) begin
					cnt_clr = 1'b1;
				end else begin
					scan_dec = 1'b1;
				end
			end
			ST_SCAN_WORDS: begin
				if (issue) begin
					ram_req.re   = 1'b1;
					ram_req.addr = scan_base + ADDR_W'(word_cnt_q);
					cnt_inc      = 1'b1;
				end
				if (found) begin
					cur_d = SLOT_W'(scan_slot_q);
				end else if (blank_done) begin
					scan_dec = 1'b1;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					load_out = 1'b1;
					res_data = (cmd_q == CMD_READ) ? ram_rdata : '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_slot_q   <= SLOT_W'(NUM_SLOTS);
			slot_valid_q <= '0;
			chk_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_slot_q <= cur_d;
			if (valid_clr) begin
				slot_valid_q <= '0;
			end else if (valid_set) begin
				slot_valid_q[cur_idx] <= 1'b1;
			end
			chk_s1 <= issue && !found;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_cmd) begin
			cmd_q <= cmd;
		end
		if (latch_wr) begin
			idx_q   <= idx;
			wdata_q <= wdata;
		end
		if (scan_load) begin
			scan_slot_q <= SIDX_W'(NUM_SLOTS - 1);
		end else if (scan_dec) begin
			scan_slot_q <= scan_slot_q - SIDX_W'(1);
		end
		if (cnt_clr) begin
			word_cnt_q <= '0;
		end else if (cnt_inc) begin
			word_cnt_q <= word_cnt_q + CNT_W'(1);
		end
		last_s1 <= fill_last;
		if (load_out) begin
			out_status_q <= res_status;
			out_data_q   <= res_data;
			out_slot_q   <= SLOT_OUT_W'(cur_d);
		end
	end

	fss_store u_store (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_slot_q, out_data_q};
	assign m_tuser  = out_status_q;

`ifndef SYNTHESIS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_slot_q <= SLOT_W'(NUM_SLOTS))
		else $error("current slot beyond not-located code");

	a_fill_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (ram_req.we && located))
		else $error("slot fill without a located slot or memory write");

	a_scan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_WORDS) |-> (scan_slot_q != '0))
		else $error("word scan reached slot zero");

	a_fill_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && state_d == ST_RESP) |=> slot_valid_q[cur_idx])
		else $error("filled slot not marked in use");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/fss_store.sv @@
// ----------------------------------------------------------------------------
// fss_store
// Sector word memory: one port, synchronous write, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_store
	import fss_pkg::*;
(
	input  wire logic              clk,
	input  wire ram_req_t          req,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [STORE_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		// The read register holds its value between reads.
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire
